// ----- sv/akbps_pkg.sv -----
// shared constants, types and functions for the key byte pair search
package akbps_pkg;
   localparam int DefaultMaxMatches = 64;
   localparam int KeySpace = 256;

   typedef enum logic [1:0] {
      FACTOR_ONE   = 2'd0,
      FACTOR_TWO   = 2'd1,
      FACTOR_THREE = 2'd2,
      FACTOR_NONE  = 2'd3
   } factor_type;

   typedef struct packed {
      logic [7:0] a_ref_byte;
      logic [7:0] a_first_byte;
      logic [7:0] a_second_byte;
      logic [7:0] b_ref_byte;
      logic [7:0] b_first_byte;
      logic [7:0] b_second_byte;
      logic [1:0] a_factor;
      logic [1:0] b_factor;
   } req_type;

   typedef struct packed {
      logic       match_valid;
      logic [7:0] guess_a;
      logic [7:0] guess_b;
      logic [5:0] match_number;
      logic       last_of_job;
      logic       overflow;
   } rsp_type;

   // match candidate handed from the sweep to the output side
   typedef struct packed {
      logic       hit;
      logic       done;
      logic [7:0] guess_a;
      logic [7:0] guess_b;
   } cand_type;

   localparam logic [7:0] INV_SBOX [KeySpace] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   function automatic logic [7:0] scale(input logic [7:0] v, input logic [1:0] code);
      logic [7:0] d;
      d = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
      case (factor_type'(code))
         FACTOR_TWO:   scale = d;
         FACTOR_THREE: scale = d ^ v;
         default:      scale = v;
      endcase
   endfunction

   function automatic logic [7:0] side_value(input logic [7:0] rb, input logic [7:0] tb,
                                             input logic [7:0] g, input logic [1:0] code);
      side_value = scale(INV_SBOX[rb ^ g] ^ INV_SBOX[tb ^ g], code);
   endfunction
endpackage

// ----- sv/akbps_if.sv -----
// valid/ready channel interfaces for requests and responses
interface akbps_req_if import akbps_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface akbps_rsp_if import akbps_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- sv/akbps_sweep.sv -----
// front: latches a job and tests one guess pair per cycle while the back has space
module akbps_sweep import akbps_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   akbps_req_if.sink req,
   output cand_type cand,
   output logic     cand_valid,
   input  logic     cand_space
);
   logic        busy_ff, busy_in;
   logic [15:0] cnt_ff, cnt_in;
   req_type     job_ff, job_in;
   logic [7:0]  va1, va2, vb1, vb2;
   logic        step;

   assign req.ready = !busy_ff;
   assign step = busy_ff && cand_space;

   // side values for the current pair
   always_comb begin
      va1 = side_value(job_ff.a_ref_byte, job_ff.a_first_byte, cnt_ff[15:8], job_ff.a_factor);
      va2 = side_value(job_ff.a_ref_byte, job_ff.a_second_byte, cnt_ff[15:8], job_ff.a_factor);
      vb1 = side_value(job_ff.b_ref_byte, job_ff.b_first_byte, cnt_ff[7:0], job_ff.b_factor);
      vb2 = side_value(job_ff.b_ref_byte, job_ff.b_second_byte, cnt_ff[7:0], job_ff.b_factor);
      cand.hit = (va1 == vb1) && (va2 == vb2);
      cand.done = (cnt_ff == 16'hffff);
      cand.guess_a = cnt_ff[15:8];
      cand.guess_b = cnt_ff[7:0];
      cand_valid = step;
   end

   // sweep control
   always_comb begin
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      job_in = job_ff;
      if (req.valid && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in = '0;
         job_in = req.data;
      end else if (step) begin
         cnt_in = cnt_ff + 16'd1;
         if (cand.done) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      job_ff <= job_in;
   end
endmodule

// ----- sv/akbps_emit.sv -----
// back: counts matches, holds the pending one and builds responses
module akbps_emit import akbps_pkg::*; #(
   parameter int MaxMatches = DefaultMaxMatches
) (
   input  logic     clock,
   input  logic     reset,
   input  cand_type cand,
   input  logic     cand_valid,
   output logic     cand_space,
   akbps_rsp_if.source rsp
);
   // cap held to the range one to sixty-four
   localparam int CapLimit = (MaxMatches < 1) ? 1 : ((MaxMatches > 64) ? 64 : MaxMatches);
   localparam logic [6:0] Cap = 7'(CapLimit);

   logic [6:0] kept_ff, kept_in;
   logic       over_ff, over_in;
   logic       pend_ff, pend_in;
   rsp_type    pend_data_ff, pend_data_in;
   logic       out_ff, out_in;
   rsp_type    out_data_ff, out_data_in;
   logic       out_free;

   assign out_free = !out_ff || rsp.ready;
   // hold back the sweep while a pending match cannot move on, while a job's final
   // response still waits, or while a no-match final response has nowhere to go
   assign cand_space = pend_ff ? (out_free && !pend_data_ff.last_of_job)
                               : (out_free || !cand.done);
   assign rsp.valid = out_ff;
   assign rsp.data = out_data_ff;

   always_comb begin
      kept_in = kept_ff;
      over_in = over_ff;
      pend_in = pend_ff;
      pend_data_in = pend_data_ff;
      out_in = out_ff && !rsp.ready;
      out_data_in = out_data_ff;
      // pending match moves to the output once it is final or the next one is known
      if (pend_ff && out_free && (pend_data_ff.last_of_job ||
                                  (cand_valid && cand.hit && kept_ff < Cap))) begin
         out_in = 1'b1;
         out_data_in = pend_data_ff;
         pend_in = 1'b0;
      end
      if (cand_valid) begin
         if (cand.hit) begin
            if (kept_ff < Cap) begin
               pend_in = 1'b1;
               pend_data_in = '{1'b1, cand.guess_a, cand.guess_b, kept_ff[5:0], 1'b0, 1'b0};
               kept_in = kept_ff + 7'd1;
            end else begin
               over_in = 1'b1;
            end
         end
         if (cand.done) begin
            if (pend_in) begin
               // last kept match becomes the final response of the job
               pend_data_in.last_of_job = 1'b1;
               pend_data_in.overflow = over_in;
            end else begin
               out_in = 1'b1;
               out_data_in = '{1'b0, 8'd0, 8'd0, 6'd0, 1'b1, 1'b0};
            end
            kept_in = '0;
            over_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_ff <= '0;
         over_ff <= 1'b0;
         pend_ff <= 1'b0;
         out_ff <= 1'b0;
      end else begin
         kept_ff <= kept_in;
         over_ff <= over_in;
         pend_ff <= pend_in;
         out_ff <= out_in;
      end
      pend_data_ff <= pend_data_in;
      out_data_ff <= out_data_in;
   end

   // a stalled response holds its payload
   assert property (@(posedge clock) disable iff (reset)
      out_ff && !rsp.ready |=> $stable(out_data_ff))
      else $error("response changed while stalled");
   // kept count never passes the cap
   assert property (@(posedge clock) disable iff (reset) kept_ff <= Cap)
      else $error("match count beyond cap");
   // sweep never steps while a pending match is blocked
   assert property (@(posedge clock) disable iff (reset)
      pend_ff && !out_free |-> !cand_valid)
      else $error("candidate lost");
endmodule

// ----- sv/aes_key_byte_pair_search_top.sv -----
// top level of the key byte pair search
// a match is held until the next kept match or the end of its job; if nothing matched,
// the final response goes straight to the output register, else via the pending register
// throughput: one pair a cycle while the back has space; a job is taken only when idle
// the sweep stalls while a pending match or a job's final response waits on a full output
// synchronous active-high reset clears all control state; no job is in flight after it
module aes_key_byte_pair_search_top import akbps_pkg::*; #(
   parameter int MaxMatches = DefaultMaxMatches
) (
   input logic clock,
   input logic reset,
   akbps_req_if.sink   req,
   akbps_rsp_if.source rsp
);
   cand_type cand;
   logic     cand_valid;
   logic     cand_space;

   akbps_sweep u_sweep (
      .clock(clock), .reset(reset), .req(req),
      .cand(cand), .cand_valid(cand_valid), .cand_space(cand_space)
   );

   akbps_emit #(.MaxMatches(MaxMatches)) u_emit (
      .clock(clock), .reset(reset),
      .cand(cand), .cand_valid(cand_valid), .cand_space(cand_space), .rsp(rsp)
   );
endmodule

// ----- test/tb_aes_key_byte_pair_search_top.sv -----
// self-checking testbench for the key byte pair search top level
`timescale 1ns / 100ps

module tb_aes_key_byte_pair_search_top;
   import akbps_pkg::*;

   localparam int WatchdogLimit = 1000000;
   localparam int HoldOffCycles = 140000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   akbps_req_if req_if ();
   akbps_rsp_if rsp_if ();

   aes_key_byte_pair_search_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   req_type pending_requests[$];
   rsp_type expected_matches[$];
   int      mismatch_count = 0;
   int      cycle_count = 0;
   int      quiet_cycles = 0;
   int      holdoff_left = 0;
   bit      holdoff_done = 0;

   // clock generation
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // gf times-two, times-three scaling; code three acts as times one
   function automatic logic [7:0] gf_scaled(input logic [7:0] v, input logic [1:0] code);
      logic [7:0] dbl;
      dbl = (v << 1) ^ (v[7] ? 8'h1b : 8'h00);
      if (code == FACTOR_TWO) return dbl;
      if (code == FACTOR_THREE) return dbl ^ v;
      return v;
   endfunction

   function automatic logic [7:0] column_diff(input logic [7:0] rb, input logic [7:0] tb,
                                              input logic [7:0] g, input logic [1:0] code);
      return gf_scaled(INV_SBOX[rb ^ g] ^ INV_SBOX[tb ^ g], code);
   endfunction

   // sweep all guess pairs of one request and queue the matches it yields
   task automatic predict_matches(input req_type r);
      logic [7:0] vb1 [KeySpace];
      logic [7:0] vb2 [KeySpace];
      logic [7:0] va1, va2;
      rsp_type    m;
      int         kept;
      bit         over;
      kept = 0;
      over = 0;
      for (int gb = 0; gb < KeySpace; gb++) begin
         vb1[gb] = column_diff(r.b_ref_byte, r.b_first_byte, gb[7:0], r.b_factor);
         vb2[gb] = column_diff(r.b_ref_byte, r.b_second_byte, gb[7:0], r.b_factor);
      end
      for (int ga = 0; ga < KeySpace; ga++) begin
         va1 = column_diff(r.a_ref_byte, r.a_first_byte, ga[7:0], r.a_factor);
         va2 = column_diff(r.a_ref_byte, r.a_second_byte, ga[7:0], r.a_factor);
         for (int gb = 0; gb < KeySpace; gb++) begin
            if (vb1[gb] == va1 && vb2[gb] == va2) begin
               if (kept < DefaultMaxMatches) begin
                  m.match_valid  = 1'b1;
                  m.guess_a      = ga[7:0];
                  m.guess_b      = gb[7:0];
                  m.match_number = kept[5:0];
                  m.last_of_job  = 1'b0;
                  m.overflow     = 1'b0;
                  expected_matches.push_back(m);
                  kept++;
               end else begin
                  over = 1;
               end
            end
         end
      end
      if (kept == 0) begin
         m = '0;
         m.last_of_job = 1'b1;
         expected_matches.push_back(m);
      end else begin
         expected_matches[$].last_of_job = 1'b1;
         expected_matches[$].overflow    = over;
      end
   endtask

   function automatic bit idle_now();
      // a recurring quiet window with no idling at all
      if ((cycle_count % 2000) < 400) return 0;
      return $urandom_range(99, 0) < 21;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.data  <= '0;
      end else if (!req_if.valid || req_if.ready) begin
         if (pending_requests.size() != 0 && !idle_now()) begin
            req_if.valid <= 1'b1;
            req_if.data  <= pending_requests.pop_front();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // response ready, with one long hold-off while requests keep coming
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (!holdoff_done && rsp_if.valid && pending_requests.size() != 0) begin
         holdoff_done <= 1;
         holdoff_left <= HoldOffCycles;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= !idle_now();
      end
   end

   // monitor: predict on accepted requests, compare accepted responses
   always @(posedge clock) begin
      rsp_type exp_m;
      if (!reset) begin
         cycle_count <= cycle_count + 1;
         if (req_if.valid && req_if.ready) predict_matches(req_if.data);
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_matches.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("unexpected response %p", rsp_if.data);
            end else begin
               exp_m = expected_matches.pop_front();
               if (exp_m !== rsp_if.data) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10)
                     $display("mismatch: expected %p actual %p", exp_m, rsp_if.data);
               end
            end
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (quiet_cycles >= WatchdogLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic req_type make_request(input logic [7:0] ar, a1, a2, br, b1, b2,
                                            input logic [1:0] af, bf);
      req_type r;
      r.a_ref_byte = ar; r.a_first_byte = a1; r.a_second_byte = a2;
      r.b_ref_byte = br; r.b_first_byte = b1; r.b_second_byte = b2;
      r.a_factor = af; r.b_factor = bf;
      return r;
   endfunction

   // stimulus and end of run
   initial begin
      req_type r;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, each factor, no match, overflow
      pending_requests.push_back(make_request(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                              FACTOR_ONE, FACTOR_ONE));
      pending_requests.push_back(make_request(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                                              FACTOR_NONE, FACTOR_NONE));
      pending_requests.push_back(make_request(8'h00, 8'hff, 8'h55, 8'hff, 8'h00, 8'haa,
                                              FACTOR_ONE, FACTOR_ONE));
      pending_requests.push_back(make_request(8'h12, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9a,
                                              FACTOR_TWO, FACTOR_THREE));
      pending_requests.push_back(make_request(8'h01, 8'h02, 8'h03, 8'h01, 8'h02, 8'h03,
                                              FACTOR_TWO, FACTOR_TWO));
      pending_requests.push_back(make_request(8'h01, 8'h02, 8'h03, 8'h01, 8'h02, 8'h03,
                                              FACTOR_THREE, FACTOR_THREE));
      pending_requests.push_back(make_request(8'ha5, 8'h5a, 8'hc3, 8'ha5, 8'h5a, 8'hc3,
                                              FACTOR_NONE, FACTOR_ONE));
      pending_requests.push_back(make_request(8'hf0, 8'h0f, 8'h3c, 8'h11, 8'h22, 8'h33,
                                              FACTOR_THREE, FACTOR_NONE));
      pending_requests.push_back(make_request(8'h80, 8'h7f, 8'h80, 8'h80, 8'h7f, 8'h80,
                                              FACTOR_ONE, FACTOR_TWO));
      pending_requests.push_back(make_request(8'h40, 8'h40, 8'h40, 8'h20, 8'h20, 8'h20,
                                              FACTOR_TWO, FACTOR_ONE));

      // random jobs, some with repeated bytes to push matches and overflow
      repeat (90) begin
         r.a_ref_byte    = 8'($urandom_range(255, 0));
         r.a_first_byte  = 8'($urandom_range(255, 0));
         r.a_second_byte = 8'($urandom_range(255, 0));
         r.b_ref_byte    = 8'($urandom_range(255, 0));
         r.b_first_byte  = 8'($urandom_range(255, 0));
         r.b_second_byte = 8'($urandom_range(255, 0));
         r.a_factor      = 2'($urandom_range(3, 0));
         r.b_factor      = 2'($urandom_range(3, 0));
         if ($urandom_range(7, 0) == 0) r.a_first_byte = r.a_ref_byte;
         if ($urandom_range(7, 0) == 0) r.b_first_byte = r.b_ref_byte;
         if ($urandom_range(9, 0) == 0) begin
            r.b_ref_byte = r.a_ref_byte;
            r.b_first_byte = r.a_first_byte;
            r.b_second_byte = r.a_second_byte;
            r.b_factor = r.a_factor;
         end
         pending_requests.push_back(r);
      end

      wait (pending_requests.size() == 0);
      @(posedge clock);
      while (req_if.valid || expected_matches.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && expected_matches.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

// ----- filelist.f -----
sv/akbps_pkg.sv
sv/akbps_if.sv
sv/akbps_sweep.sv
sv/akbps_emit.sv
sv/aes_key_byte_pair_search_top.sv
test/tb_aes_key_byte_pair_search_top.sv
